// ===== rtl/assert_macros.svh =====
// assertion macros for the record store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a must be followed in the same cycle by b
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// a must be followed in the next cycle by b
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ===== rtl/crs_pkg.sv =====
package crs_pkg;

   localparam int HDR_BYTES = 3;
   localparam int MAX_DATA = 29;
   localparam logic [7:0] FILL_VALUE = 8'hFF;
   localparam logic [7:0] BAD_ID = 8'hFF;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_DATA = 3'd1;
   localparam logic [2:0] ACT_DELETE = 3'd2;
   localparam logic [2:0] ACT_READ = 3'd3;
   localparam logic [2:0] ACT_COMPACT = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_NO_SPACE = 3'd2;
   localparam logic [2:0] ST_TOO_LONG = 3'd3;
   localparam logic [2:0] ST_UNEXPECTED = 3'd4;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] record_id;
      logic [4:0] data_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       last;
      logic [3:0] record_count;
      logic [5:0] used_bytes;
   } rsp_type;

endpackage

// ===== rtl/compacting_record_store_core.sv =====
// channel | ports                          | direction
// req     | req_valid req_ready req_data   | in
// rsp     | rsp_valid rsp_ready rsp_data   | out
//
// one transaction at a time; a data byte goes through S_DATA, a lookup through L_HEAD,
// L_FLAG, L_ID and L_LEN per record header, and a read through R_ADDR and R_DATA per byte.
// compaction reads each record header in C_HEAD, C_FLAG and C_LEN, copies each kept byte
// through C_RD and C_WR, and fills each freed byte in C_FILL.
// after reset a clearing pass fills the store with 255.
// a stalled rsp holds its result register; req waits until the block is idle.
`include "assert_macros.svh"

module compacting_record_store_core #(
   parameter int STORE_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crs_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int AW1 = AW + 1;
   localparam int SW = $clog2(STORE_BYTES + 512);
   localparam logic [SW-1:0] N_S = SW'(STORE_BYTES);
   localparam logic [SW-1:0] HDR_S = SW'(crs_pkg::HDR_BYTES);
   localparam logic [SW-1:0] MAXREC_S = SW'(crs_pkg::HDR_BYTES + crs_pkg::MAX_DATA);
   localparam logic [AW1-1:0] LAST_A = AW1'(STORE_BYTES - 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DATA, S_EMIT,
      L_HEAD, L_FLAG, L_ID, L_LEN, D_OP,
      C_HEAD, C_FLAG, C_LEN, C_RD, C_WR, C_FILL,
      A_CHK, A_H1, A_H2, R_ADDR, R_DATA
   } state_type;

   logic [7:0] store_mem_ff [STORE_BYTES];
   logic [7:0] mem_q_ff;
   logic       mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0] mem_wd;

   state_type state_ff, state_in;
   logic [AW1-1:0] clr_ff, clr_in;
   crs_pkg::req_type cmd_ff, cmd_in;
   logic [SW-1:0] p_ff, p_in, rd_ff, rd_in, wr_ff, wr_in, size_ff, size_in, cnt_ff, cnt_in;
   logic found_ff, found_in, flag_ff, flag_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [7:0] poslen_ff, poslen_in;
   logic [AW1-1:0] ap_ff, ap_in, lb_ff, lb_in, fp_ff, fp_in;
   logic [AW-1:0] lr_ff, lr_in;
   logic [4:0] btf_ff, btf_in;
   logic [2:0] em_status_ff, em_status_in;
   logic [7:0] em_byte_ff, em_byte_in;
   logic em_last_ff, em_last_in;
   logic rsp_valid_ff, rsp_valid_in;
   crs_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] ap_s, lb_s, len_s, kill_s, free_s, rsize_s, csize_s;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      ap_s = SW'(ap_ff);
      lb_s = SW'(lb_ff);
      len_s = SW'(cmd_ff.data_length);
      kill_s = HDR_S + SW'(poslen_ff);
      free_s = ((lb_s < N_S) ? N_S - lb_s : '0) + (found_ff ? kill_s : '0);
      rsize_s = kill_s;
      if (rsize_s > MAXREC_S) rsize_s = MAXREC_S;
      if (SW'(pos_ff) + rsize_s > N_S) rsize_s = N_S - SW'(pos_ff);
      csize_s = HDR_S + SW'(mem_q_ff);
      if (rd_ff + csize_s > N_S) csize_s = N_S - rd_ff;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      p_in = p_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      size_in = size_ff;
      cnt_in = cnt_ff;
      found_in = found_ff;
      flag_in = flag_ff;
      pos_in = pos_ff;
      poslen_in = poslen_ff;
      ap_in = ap_ff;
      lb_in = lb_ff;
      fp_in = fp_ff;
      lr_in = lr_ff;
      btf_in = btf_ff;
      em_status_in = em_status_ff;
      em_byte_in = em_byte_ff;
      em_last_in = em_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in = rsp_ff;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[AW-1:0];
            mem_wd = crs_pkg::FILL_VALUE;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_A) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               em_byte_in = '0;
               em_last_in = 1'b1;
               em_status_in = crs_pkg::ST_UNEXPECTED;
               p_in = '0;
               rd_in = '0;
               wr_in = '0;
               found_in = 1'b0;
               if (req_data.action != crs_pkg::ACT_DATA) btf_in = '0;
               case (req_data.action)
                  crs_pkg::ACT_ADD: begin
                     state_in = (req_data.record_id == crs_pkg::BAD_ID) ? S_EMIT : L_HEAD;
                  end
                  crs_pkg::ACT_DATA: state_in = S_DATA;
                  crs_pkg::ACT_DELETE: state_in = L_HEAD;
                  crs_pkg::ACT_READ: state_in = L_HEAD;
                  crs_pkg::ACT_COMPACT: state_in = C_HEAD;
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_DATA: begin
            if (btf_ff == '0 || fp_ff >= AW1'(STORE_BYTES)) begin
               btf_in = '0;
               em_status_in = crs_pkg::ST_UNEXPECTED;
            end else begin
               mem_we = 1'b1;
               mem_wa = fp_ff[AW-1:0];
               mem_wd = cmd_ff.data_byte;
               fp_in = fp_ff + 1'b1;
               btf_in = btf_ff - 1'b1;
               em_status_in = crs_pkg::ST_OK;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = em_status_ff;
               rsp_in.out_byte = em_byte_ff;
               rsp_in.last = em_last_ff;
               rsp_in.record_count = 4'(lr_ff);
               rsp_in.used_bytes = 6'(lb_ff);
               state_in = em_last_ff ? S_IDLE : R_ADDR;
            end
         end
         L_HEAD: begin
            if (p_ff < ap_s && p_ff + 2 < N_S) begin
               mem_re = 1'b1;
               mem_ra = p_ff[AW-1:0];
               state_in = L_FLAG;
            end else begin
               found_in = 1'b0;
               state_in = D_OP;
            end
         end
         L_FLAG: begin
            flag_in = (mem_q_ff != 8'd0);
            mem_re = 1'b1;
            mem_ra = AW'(p_ff + 1);
            state_in = L_ID;
         end
         L_ID: begin
            flag_in = flag_ff && (mem_q_ff == cmd_ff.record_id);
            mem_re = 1'b1;
            mem_ra = AW'(p_ff + 2);
            state_in = L_LEN;
         end
         L_LEN: begin
            if (flag_ff) begin
               found_in = 1'b1;
               pos_in = p_ff[AW-1:0];
               poslen_in = mem_q_ff;
               state_in = D_OP;
            end else begin
               p_in = p_ff + HDR_S + SW'(mem_q_ff);
               state_in = L_HEAD;
            end
         end
         D_OP: begin
            em_status_in = crs_pkg::ST_OK;
            state_in = S_EMIT;
            case (cmd_ff.action)
               crs_pkg::ACT_ADD: begin
                  if (free_s < HDR_S) begin
                     em_status_in = crs_pkg::ST_NO_SPACE;
                  end else if (len_s > free_s - HDR_S ||
                               len_s > SW'(crs_pkg::MAX_DATA)) begin
                     em_status_in = crs_pkg::ST_TOO_LONG;
                  end else begin
                     if (found_ff) begin
                        mem_we = 1'b1;
                        mem_wa = pos_ff;
                        lr_in = (lr_ff != '0) ? lr_ff - 1'b1 : '0;
                        lb_in = (lb_s > kill_s) ? AW1'(lb_s - kill_s) : '0;
                     end
                     state_in = (ap_s + HDR_S + len_s > N_S) ? C_HEAD : A_CHK;
                  end
               end
               crs_pkg::ACT_DELETE: begin
                  if (found_ff) begin
                     mem_we = 1'b1;
                     mem_wa = pos_ff;
                     lr_in = (lr_ff != '0) ? lr_ff - 1'b1 : '0;
                     lb_in = (lb_s > kill_s) ? AW1'(lb_s - kill_s) : '0;
                  end else begin
                     em_status_in = crs_pkg::ST_NOT_FOUND;
                  end
               end
               crs_pkg::ACT_READ: begin
                  if (found_ff) begin
                     size_in = rsize_s;
                     cnt_in = '0;
                     state_in = R_ADDR;
                  end else begin
                     em_status_in = crs_pkg::ST_NOT_FOUND;
                  end
               end
               default: em_status_in = crs_pkg::ST_UNEXPECTED;
            endcase
         end
         C_HEAD: begin
            if (rd_ff < ap_s && rd_ff + 2 < N_S) begin
               mem_re = 1'b1;
               mem_ra = rd_ff[AW-1:0];
               state_in = C_FLAG;
            end else begin
               rd_in = wr_ff;
               state_in = C_FILL;
            end
         end
         C_FLAG: begin
            flag_in = (mem_q_ff != 8'd0);
            mem_re = 1'b1;
            mem_ra = AW'(rd_ff + 2);
            state_in = C_LEN;
         end
         C_LEN: begin
            size_in = csize_s;
            cnt_in = '0;
            if (flag_ff) begin
               state_in = C_RD;
            end else begin
               rd_in = rd_ff + csize_s;
               state_in = C_HEAD;
            end
         end
         C_RD: begin
            mem_re = 1'b1;
            mem_ra = AW'(rd_ff + cnt_ff);
            state_in = C_WR;
         end
         C_WR: begin
            mem_we = 1'b1;
            mem_wa = AW'(wr_ff + cnt_ff);
            mem_wd = mem_q_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1 == size_ff) begin
               wr_in = wr_ff + size_ff;
               rd_in = rd_ff + size_ff;
               state_in = C_HEAD;
            end else begin
               state_in = C_RD;
            end
         end
         C_FILL: begin
            if (rd_ff < ap_s && rd_ff < N_S) begin
               mem_we = 1'b1;
               mem_wa = rd_ff[AW-1:0];
               mem_wd = crs_pkg::FILL_VALUE;
               rd_in = rd_ff + 1'b1;
            end else begin
               ap_in = AW1'(wr_ff);
               em_status_in = crs_pkg::ST_OK;
               state_in = (cmd_ff.action == crs_pkg::ACT_ADD) ? A_CHK : S_EMIT;
            end
         end
         A_CHK: begin
            if (ap_s + HDR_S + len_s <= N_S) begin
               mem_we = 1'b1;
               mem_wa = ap_ff[AW-1:0];
               mem_wd = 8'd1;
               state_in = A_H1;
            end else begin
               em_status_in = crs_pkg::ST_NO_SPACE;
               state_in = S_EMIT;
            end
         end
         A_H1: begin
            mem_we = 1'b1;
            mem_wa = AW'(ap_ff + 1'b1);
            mem_wd = cmd_ff.record_id;
            state_in = A_H2;
         end
         A_H2: begin
            mem_we = 1'b1;
            mem_wa = AW'(ap_ff + 2'd2);
            mem_wd = 8'(cmd_ff.data_length);
            fp_in = AW1'(ap_s + HDR_S);
            btf_in = cmd_ff.data_length;
            ap_in = AW1'(ap_s + HDR_S + len_s);
            lr_in = lr_ff + 1'b1;
            lb_in = AW1'(lb_s + HDR_S + len_s);
            em_status_in = crs_pkg::ST_OK;
            state_in = S_EMIT;
         end
         R_ADDR: begin
            mem_re = 1'b1;
            mem_ra = AW'(SW'(pos_ff) + cnt_ff);
            state_in = R_DATA;
         end
         R_DATA: begin
            em_status_in = crs_pkg::ST_OK;
            em_byte_in = mem_q_ff;
            em_last_in = (cnt_ff + 1 == size_ff);
            cnt_in = cnt_ff + 1'b1;
            state_in = S_EMIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem_ff[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= store_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ap_ff <= '0;
         lb_ff <= '0;
         fp_ff <= '0;
         lr_ff <= '0;
         btf_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ap_ff <= ap_in;
         lb_ff <= lb_in;
         fp_ff <= fp_in;
         lr_ff <= lr_in;
         btf_ff <= btf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      p_ff <= p_in;
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      size_ff <= size_in;
      cnt_ff <= cnt_in;
      found_ff <= found_in;
      flag_ff <= flag_in;
      pos_ff <= pos_in;
      poslen_ff <= poslen_in;
      em_status_ff <= em_status_in;
      em_byte_ff <= em_byte_in;
      em_last_ff <= em_last_in;
      rsp_ff <= rsp_in;
   end

   `ASSERT_IMPLIES(a_fill_in_record, clock, reset, btf_ff != '0,
      SW'(fp_ff) + SW'(btf_ff) <= SW'(ap_ff))
   `ASSERT_IMPLIES(a_live_fits, clock, reset, 1'b1,
      lb_ff <= AW1'(STORE_BYTES) && ap_ff <= AW1'(STORE_BYTES))
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule
